@@ rtl/chacha_pkg.sv @@
// ----------------------------------------------------------------------------
// chacha_pkg
// shared types, constants and helpers for the chacha20 stream cipher unit
// ----------------------------------------------------------------------------
package chacha_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] block_t;

  // "expand 32-byte k" as little-endian words
  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  // configuration register indexes
  localparam logic [2:0] CFG_KEY_0    = 3'd0;
  localparam logic [2:0] CFG_KEY_1    = 3'd1;
  localparam logic [2:0] CFG_KEY_2    = 3'd2;
  localparam logic [2:0] CFG_KEY_3    = 3'd3;
  localparam logic [2:0] CFG_NONCE_LO = 3'd4;
  localparam logic [2:0] CFG_NONCE_HI = 3'd5;
  localparam logic [2:0] CFG_INIT_CTR = 3'd6;

  // quarter-round phases: a+=b d^=a, c+=d b^=c, a+=b d^=a, c+=d b^=c
  localparam logic [1:0] PH_AD16 = 2'd0;
  localparam logic [1:0] PH_CB12 = 2'd1;
  localparam logic [1:0] PH_AD8  = 2'd2;
  localparam logic [1:0] PH_CB7  = 2'd3;

  typedef struct packed {
    logic       load_in;   // capture input word
    logic       init;      // load state from key, nonce and counter
    logic       round;     // one quarter-round phase on all four lanes
    logic       diag;      // diagonal round when set, column round otherwise
    logic [1:0] phase;     // quarter-round phase
    logic       fin;       // add original state back into keystream
    logic       emit;      // load output register and advance position, or clear it at message end
  } cmd_t;

  typedef struct packed {
    logic need_block;      // position is at the start of a block
    logic out_free;        // output register can take a word this cycle
  } sts_t;

  // rotate left by the amount that belongs to the phase
  function automatic word_t qstep_rot(word_t v, logic [1:0] ph);
    word_t r;
    case (ph)
      PH_AD16: r = {v[15:0], v[31:16]};
      PH_CB12: r = {v[19:0], v[31:20]};
      PH_AD8:  r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

  // state word index of row for a lane; diagonal rounds skew each row
  function automatic logic [3:0] word_idx(logic [1:0] row, logic [1:0] lane,
                                          logic diag);
    logic [1:0] col;
    col = diag ? lane + row : lane;
    return {row, col};
  endfunction

endpackage

@@ rtl/chacha_ctrl.sv @@
// ----------------------------------------------------------------------------
// chacha_ctrl
// sequencer: accept a byte, run the block rounds when needed, emit the result
// ----------------------------------------------------------------------------
module chacha_ctrl #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  chacha_pkg::sts_t sts,
  output chacha_pkg::cmd_t cmd
);
  import chacha_pkg::*;

  localparam int DR_W = $clog2(DOUBLE_ROUNDS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FINAL = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [2:0]      step_r, step_nxt;      // {diag, phase}
  logic [DR_W-1:0] dr_r, dr_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    dr_nxt    = dr_r;
    cmd       = '0;
    in_tready = 1'b0;
    cmd.diag  = step_r[2];
    cmd.phase = step_r[1:0];
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = sts.need_block ? ST_INIT : ST_EMIT;
        end
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        step_nxt  = '0;
        dr_nxt    = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        step_nxt  = step_r + 3'd1;
        if (step_r == 3'd7) begin
          if (dr_r == DR_W'(DOUBLE_ROUNDS - 1)) begin
            state_nxt = ST_FINAL;
          end else begin
            dr_nxt = dr_r + DR_W'(1);
          end
        end
      end
      ST_FINAL: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      dr_r    <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      dr_r    <= dr_nxt;
    end
  end

endmodule

@@ rtl/chacha_dp.sv @@
// ----------------------------------------------------------------------------
// chacha_dp
// datapath: config registers, round state, keystream block, output register
// ----------------------------------------------------------------------------
module chacha_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_wdata,
  input  logic [7:0]       in_tdata,
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  input  chacha_pkg::cmd_t cmd,
  output chacha_pkg::sts_t sts
);
  import chacha_pkg::*;

  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce_lo_r;
  logic [31:0] nonce_hi_r, init_ctr_r;

  block_t      w_r, w_nxt, round_w, init_w;
  word_t       ks_r [16];
  word_t       ctr_word_r, ctr_sel;
  logic [5:0]  pos_r;
  logic [31:0] blk_r;
  logic [7:0]  hold_data_r;
  logic        hold_last_r;
  logic        out_tvalid_r;
  logic [7:0]  out_tdata_r;
  logic        out_tlast_r;
  word_t       ks_word, ks_shift;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r     <= '0;
      key1_r     <= '0;
      key2_r     <= '0;
      key3_r     <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
      init_ctr_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_KEY_0:    key0_r     <= cfg_wdata;
        CFG_KEY_1:    key1_r     <= cfg_wdata;
        CFG_KEY_2:    key2_r     <= cfg_wdata;
        CFG_KEY_3:    key3_r     <= cfg_wdata;
        CFG_NONCE_LO: nonce_lo_r <= cfg_wdata;
        CFG_NONCE_HI: nonce_hi_r <= cfg_wdata[31:0];
        CFG_INIT_CTR: init_ctr_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // original state; counter word is freshly summed at init, held afterwards
  always_comb begin
    ctr_sel    = cmd.init ? init_ctr_r + blk_r : ctr_word_r;
    init_w[0]  = SIGMA_0;
    init_w[1]  = SIGMA_1;
    init_w[2]  = SIGMA_2;
    init_w[3]  = SIGMA_3;
    init_w[4]  = key0_r[31:0];
    init_w[5]  = key0_r[63:32];
    init_w[6]  = key1_r[31:0];
    init_w[7]  = key1_r[63:32];
    init_w[8]  = key2_r[31:0];
    init_w[9]  = key2_r[63:32];
    init_w[10] = key3_r[31:0];
    init_w[11] = key3_r[63:32];
    init_w[12] = ctr_sel;
    init_w[13] = nonce_lo_r[31:0];
    init_w[14] = nonce_lo_r[63:32];
    init_w[15] = nonce_hi_r;
  end

  // four quarter-round lanes, one add-xor-rotate each per cycle
  always_comb begin
    logic [3:0] ia, ib, ic, id, xi, yi, zi;
    word_t      sum;
    round_w = w_r;
    for (int l = 0; l < 4; l++) begin
      ia  = word_idx(2'd0, 2'(l), cmd.diag);
      ib  = word_idx(2'd1, 2'(l), cmd.diag);
      ic  = word_idx(2'd2, 2'(l), cmd.diag);
      id  = word_idx(2'd3, 2'(l), cmd.diag);
      xi  = cmd.phase[0] ? ic : ia;
      yi  = cmd.phase[0] ? id : ib;
      zi  = cmd.phase[0] ? ib : id;
      sum = w_r[xi] + w_r[yi];
      round_w[xi] = sum;
      round_w[zi] = qstep_rot(w_r[zi] ^ sum, cmd.phase);
    end
  end

  always_comb begin
    if (cmd.init) begin
      w_nxt = init_w;
    end else if (cmd.round) begin
      w_nxt = round_w;
    end else begin
      w_nxt = w_r;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (cmd.init) begin
      ctr_word_r <= ctr_sel;
    end
    if (cmd.fin) begin
      for (int i = 0; i < 16; i++) begin
        ks_r[i] <= w_r[i] + init_w[i];
      end
    end
    if (cmd.load_in) begin
      hold_data_r <= in_tdata;
      hold_last_r <= in_tlast;
    end
  end

  // keystream byte at the current position, little-endian within the word
  assign ks_word  = ks_r[pos_r[5:2]];
  assign ks_shift = ks_word >> {pos_r[1:0], 3'b000};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tdata_r <= hold_data_r ^ ks_shift[7:0];
      out_tlast_r <= hold_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      blk_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_tvalid_r <= 1'b1;
        if (hold_last_r) begin
          pos_r <= '0;
          blk_r <= '0;
        end else begin
          pos_r <= pos_r + 6'd1;
          if (pos_r == 6'd63) begin
            blk_r <= blk_r + 32'd1;
          end
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign sts.need_block = (pos_r == 6'd0);
  assign sts.out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

@@ rtl/chacha20_stream_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_unit
// ietf chacha20 byte stream cipher, same operation for encrypt and decrypt
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one plaintext or ciphertext byte per word, in_tlast ends a message
//   out_* : one transformed byte per word, out_tlast copies in_tlast
//   cfg_* : key (indexes 0-3), nonce (4-5) and initial block counter (6),
//           written only while the unit is idle; they apply from the next
//           keystream block computed
// timing:
//   a byte inside a block: accepted into the hold register, then written to the
//   output register once that register is free
//   a byte at block start (position 0): the keystream block is built first by
//   a four-lane quarter-round unit, one add-xor-rotate step per cycle, through
//   the init, round and final-add states before the byte is emitted
//   the unit takes no new byte until the one it holds has been emitted
// reset: rst_n (synchronous) clears config to zero, position and block count
//   to zero; the first byte always starts a new block
// stall: a result waits in the output register; the unit takes one more byte
//   and holds it until out_tready frees the register
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_unit #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // message_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast    // out_last
);
  import chacha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: idle, init, rounds, final add, emit
  chacha_ctrl #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // state words, keystream block, counters and output register
  chacha_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ bench/chacha20_stream_cipher_unit_tb.sv @@
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_unit_tb
// self-checking bench: byte streams with random gaps and stalls go through the
// cipher unit under several key, nonce and counter settings, and every output
// word is compared with a keystream predictor kept inside the bench
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chacha_pkg::*;

  // keystream predictor and store of expected output words
  class cipher_scoreboard;
    logic [63:0] key_q[4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [31:0] ctr_init;

    logic [31:0] ks[16];
    logic [31:0] mix[16];
    logic [5:0]  pos;
    logic [31:0] blk_num;
    bit          have_block;
    int          rounds;

    logic [7:0] exp_byte_q[$];
    bit         exp_last_q[$];

    int errors;
    int checked;
    int accepted;
    int msgs;
    int blocks;

    function new(int dr);
      rounds = dr;
      foreach (key_q[i]) key_q[i] = '0;
      nonce_lo   = '0;
      nonce_hi   = '0;
      ctr_init   = '0;
      pos        = '0;
      blk_num    = '0;
      have_block = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        CFG_KEY_0:    key_q[0] = v;
        CFG_KEY_1:    key_q[1] = v;
        CFG_KEY_2:    key_q[2] = v;
        CFG_KEY_3:    key_q[3] = v;
        CFG_NONCE_LO: nonce_lo = v;
        CFG_NONCE_HI: nonce_hi = v[31:0];
        CFG_INIT_CTR: ctr_init = v[31:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
    endfunction

    function void make_keystream(logic [31:0] ctr_word);
      logic [31:0] init[16];
      init[0] = SIGMA_0;
      init[1] = SIGMA_1;
      init[2] = SIGMA_2;
      init[3] = SIGMA_3;
      for (int i = 0; i < 4; i++) begin
        init[4 + 2 * i]     = key_q[i][31:0];
        init[4 + 2 * i + 1] = key_q[i][63:32];
      end
      init[12] = ctr_word;
      init[13] = nonce_lo[31:0];
      init[14] = nonce_lo[63:32];
      init[15] = nonce_hi;
      mix = init;
      for (int r = 0; r < rounds; r++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks[i] = mix[i] + init[i];
    endfunction

    // accepted input word: predict its output word
    function void note_byte(logic [7:0] b, logic l);
      logic [7:0] k;
      if (pos == 0 || !have_block) begin
        make_keystream(ctr_init + blk_num);
        have_block = 1;
        blocks++;
      end
      k = ks[pos[5:2]][{pos[1:0], 3'b000} +: 8];
      exp_byte_q.push_back(b ^ k);
      exp_last_q.push_back(l);
      accepted++;
      if (l) begin
        pos        = '0;
        blk_num    = '0;
        have_block = 0;
        msgs++;
      end else if (pos == 6'd63) begin
        pos        = '0;
        blk_num    = blk_num + 32'd1;
        have_block = 0;
      end else begin
        pos = pos + 6'd1;
      end
    endfunction

    // accepted output word: compare with the oldest prediction
    function void check_byte(logic [7:0] b, logic l);
      logic [7:0] eb;
      bit         el;
      if (exp_byte_q.size() == 0) begin
        $error("unexpected output word: out_byte %h out_last %b", b, l);
        errors++;
        return;
      end
      eb = exp_byte_q.pop_front();
      el = exp_last_q.pop_front();
      if (b !== eb) begin
        $error("out_byte mismatch: expected %h actual %h", eb, b);
        errors++;
      end
      if (l !== el) begin
        $error("out_last mismatch: expected %b actual %b", el, l);
        errors++;
      end
      checked++;
    endfunction

    function int pending();
      return exp_byte_q.size();
    endfunction
  endclass

  localparam int DR           = 10;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 215;
  localparam int HOLD_AT      = 900;      // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8 * DR + 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // index past the last register, writes to it must do nothing
  localparam logic [2:0] CFG_SPARE_INDEX = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [7:0] data_byte
  logic        in_tlast = 1'b0;   // message_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] out_byte
  logic        out_tlast;         // out_last

  cipher_scoreboard sb = new(DR);

  int  tx_idle_pct = 20;
  int  rx_idle_pct = 20;
  int  cycle_count = 0;
  int  in_stalls = 0;
  int  settings = 0;
  bit  long_hold_done = 0;

  chacha20_stream_cipher_unit #(.DOUBLE_ROUNDS(DR)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // cycle count for the timeout, and how often the input was held back
  always @(posedge clk) begin
    cycle_count++;
    if (in_tvalid && !in_tready) in_stalls++;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("chacha20_stream_cipher_unit: mismatch");
    $finish;
  end

  // idle length: mostly none, often short, now and then long
  function automatic int pick_gap(int pct);
    int r;
    if ($urandom_range(0, 99) >= pct) return 0;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // message length: short ones, ones near a block, and ones over several blocks
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(1, 8);
    if (r < 75) return $urandom_range(9, 70);
    return $urandom_range(100, 200);
  endfunction

  function automatic logic [63:0] pick_word(int mode);
    case (mode)
      0:       return '0;
      1:       return '1;
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // receiver: checks every accepted output word, stalls at random, and once
  // holds off for a long stretch so the unit backs up into its input
  initial begin
    int hold_left;
    int g;
    bit nxt;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast);
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (!long_hold_done && sb.checked >= HOLD_AT) begin
        long_hold_done = 1;
        hold_left      = HOLD_CYCLES - 1;
        nxt            = 1'b0;
      end else begin
        g = pick_gap(rx_idle_pct);
        if (g > 0) begin
          hold_left = g - 1;
          nxt       = 1'b0;
        end else begin
          nxt = 1'b1;
        end
      end
      out_tready <= nxt;
    end
  end

  // offer one byte, wait for the handshake, then maybe idle
  task automatic push_byte(input logic [7:0] b, input logic l);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, l);
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // run of random bytes, optionally closed by tlast on the final one
  task automatic send_run(input int len, input bit close);
    for (int i = 0; i < len; i++)
      push_byte(8'($urandom), close && (i == len - 1));
  endtask

  // drop valid and wait until every predicted word has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write; the strobe stays high for back-to-back writes
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic cfg_release();
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // new key, nonce and counter for a random phase; upper bits of the 32-bit
  // registers carry junk that must be dropped
  task automatic configure_phase(input int ph);
    logic [63:0] v;
    int          mode;
    int          pick;
    mode = (ph == 1) ? 0 : (ph == 2) ? 1 : -1;
    write_reg(CFG_KEY_0, pick_word(mode < 0 ? $urandom_range(0, 3) : mode));
    write_reg(CFG_KEY_1, pick_word(mode < 0 ? $urandom_range(0, 3) : mode));
    write_reg(CFG_KEY_2, pick_word(mode < 0 ? $urandom_range(0, 3) : mode));
    write_reg(CFG_KEY_3, pick_word(mode < 0 ? $urandom_range(0, 3) : mode));
    write_reg(CFG_NONCE_LO, pick_word(mode < 0 ? $urandom_range(0, 3) : mode));
    v = pick_word(mode < 0 ? $urandom_range(0, 3) : mode);
    write_reg(CFG_NONCE_HI, {32'($urandom), v[31:0]});
    // counter near the top so blocks wrap past zero, plus the extremes
    pick = (ph == 0) ? 1 : (ph == 1) ? 0 : $urandom_range(0, 3);
    case (pick)
      0:       v[31:0] = 32'h0000_0000;
      1:       v[31:0] = 32'hffff_ffff;
      2:       v[31:0] = 32'hffff_fffe;
      default: v[31:0] = 32'($urandom);
    endcase
    write_reg(CFG_INIT_CTR, {32'($urandom), v[31:0]});
    if ($urandom_range(0, 1)) write_reg(CFG_SPARE_INDEX, pick_word(2));
    cfg_release();
  endtask

  initial begin
    int sent;
    int len;
    bit close;
    int pcts[3];
    pcts = '{0, 15, 50};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // reset config: all-zero key, nonce and counter
    push_byte(8'h00, 1'b1);
    settle();

    // all-ones key and nonce, counter at its top, junk in the upper bits,
    // and a write past the last register
    write_reg(CFG_KEY_0, '1);
    write_reg(CFG_KEY_1, '1);
    write_reg(CFG_KEY_2, '1);
    write_reg(CFG_KEY_3, '1);
    write_reg(CFG_NONCE_LO, '1);
    write_reg(CFG_NONCE_HI, {32'($urandom), 32'hffff_ffff});
    write_reg(CFG_INIT_CTR, {32'($urandom), 32'hffff_ffff});
    write_reg(CFG_SPARE_INDEX, pick_word(2));
    cfg_release();
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h5a, 1'b0);
    push_byte(8'ha5, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'hff, 1'b1);

    // registers written in the middle of a block: the rest of that block
    // still uses the old keystream, the next message the new one
    send_run(5, 1'b0);
    settle();
    write_reg(CFG_KEY_0, pick_word(2));
    write_reg(CFG_NONCE_LO, pick_word(2));
    cfg_release();
    send_run(3, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b1);

    // ---- random phases ----
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      configure_phase(ph);
      // one phase runs with no idling on either side
      tx_idle_pct = (ph == 3) ? 0 : pcts[$urandom_range(0, 2)];
      rx_idle_pct = (ph == 3) ? 0 : pcts[$urandom_range(0, 2)];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len   = (ph == 0 && sent == 0) ? 130 : pick_len();
        close = 1'b1;
        // the last run of a phase may stay open across the next writes
        if (sent + len >= PHASE_ITEMS) begin
          len   = PHASE_ITEMS - sent;
          close = $urandom_range(0, 1);
        end
        send_run(len, close);
        sent += len;
      end
    end

    // ---- drain ----
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d bytes, %0d closed messages, %0d keystream blocks, %0d settings",
             sb.accepted, sb.msgs, sb.blocks, settings);
    $display("long receiver hold-off done: %0d, input held back on %0d cycles",
             long_hold_done, in_stalls);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("chacha20_stream_cipher_unit: match");
    end else begin
      $display("chacha20_stream_cipher_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ chacha20_stream_cipher_unit.f @@
rtl/chacha_pkg.sv
rtl/chacha_ctrl.sv
rtl/chacha_dp.sv
rtl/chacha20_stream_cipher_unit.sv
bench/chacha20_stream_cipher_unit_tb.sv
